### sv/sen_pkg.sv
package sen_pkg;

    // CORDIC datapath width: Q2.30 values plus headroom for the vectoring gain
    localparam int CW = 34;

    typedef logic signed [CW-1:0] t_cw;

    localparam t_cw GAIN_Q30 = 34'sd652032874;
    localparam t_cw ONE_Q30  = 34'sd1073741824;

    // configuration register indexes
    localparam logic [2:0] CFG_LAT   = 3'd0;
    localparam logic [2:0] CFG_LON   = 3'd1;
    localparam logic [2:0] CFG_LOCV  = 3'd2;
    localparam logic [2:0] CFG_AUTO  = 3'd3;
    localparam logic [2:0] CFG_LEVEL = 3'd4;

    // arctangent of 2^-i in Q0.32 turns; zero past the last listed entry
    function automatic logic [31:0] atan_turn(input logic [5:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:    v = 32'h2000_0000;
            6'd1:    v = 32'h12E4_051E;
            6'd2:    v = 32'h09FB_385B;
            6'd3:    v = 32'h0511_11D4;
            6'd4:    v = 32'h028B_0D43;
            6'd5:    v = 32'h0145_D7E1;
            6'd6:    v = 32'h00A2_F61E;
            6'd7:    v = 32'h0051_7C55;
            6'd8:    v = 32'h0028_BE53;
            6'd9:    v = 32'h0014_5F2F;
            6'd10:   v = 32'h000A_2F98;
            6'd11:   v = 32'h0005_17CC;
            6'd12:   v = 32'h0002_8BE6;
            6'd13:   v = 32'h0001_45F3;
            6'd14:   v = 32'h0000_A2FA;
            6'd15:   v = 32'h0000_517D;
            6'd16:   v = 32'h0000_28BE;
            6'd17:   v = 32'h0000_145F;
            6'd18:   v = 32'h0000_0A30;
            6'd19:   v = 32'h0000_0518;
            6'd20:   v = 32'h0000_028C;
            6'd21:   v = 32'h0000_0146;
            6'd22:   v = 32'h0000_00A3;
            6'd23:   v = 32'h0000_0051;
            6'd24:   v = 32'h0000_0029;
            6'd25:   v = 32'h0000_0014;
            6'd26:   v = 32'h0000_000A;
            6'd27:   v = 32'h0000_0005;
            6'd28:   v = 32'h0000_0003;
            6'd29:   v = 32'h0000_0001;
            6'd30:   v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

### sv/sen_delay.sv
// Plain shift line to keep side data aligned with the CORDIC stages
module sen_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_d
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_d;
        for (int k = 1; k < DEPTH; k++) begin
            r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_d = r_tap[DEPTH-1];

endmodule

### sv/sen_cordic_rot.sv
// Pipelined CORDIC rotation: Q0.32 turn in, Q2.30 cosine and sine out.
module sen_cordic_rot import sen_pkg::*; #(
    parameter int STEPS = 32
) (
    input  logic        i_clk,
    input  logic [31:0] i_angle,
    output t_cw         o_cos,
    output t_cw         o_sin
);

    t_cw  r_x    [STEPS+1];
    t_cw  r_y    [STEPS+1];
    t_cw  r_z    [STEPS+1];
    logic r_flip [STEPS+1];
    t_cw  z_raw;
    t_cw  z_alt;
    logic [31:0] ang_alt;

    always_comb begin
        ang_alt = i_angle + 32'h8000_0000;
        z_raw   = $signed({{(CW-32){i_angle[31]}}, i_angle});
        z_alt   = $signed({{(CW-32){ang_alt[31]}}, ang_alt});
    end

    // fold the angle into the half turn the iterations converge on
    always_ff @(posedge i_clk) begin
        r_x[0] <= GAIN_Q30;
        r_y[0] <= '0;
        if (z_raw > ONE_Q30 || z_raw < -ONE_Q30) begin
            r_z[0]    <= z_alt;
            r_flip[0] <= 1'b1;
        end else begin
            r_z[0]    <= z_raw;
            r_flip[0] <= 1'b0;
        end
    end

    // one micro-rotation per stage
    for (genvar gi = 0; gi < STEPS; gi++) begin : g_iter
        t_cw atn;
        assign atn = $signed({{(CW-32){1'b0}}, atan_turn(6'(gi))});
        always_ff @(posedge i_clk) begin
            if (r_z[gi] >= 0) begin
                r_x[gi+1] <= r_x[gi] - (r_y[gi] >>> gi);
                r_y[gi+1] <= r_y[gi] + (r_x[gi] >>> gi);
                r_z[gi+1] <= r_z[gi] - atn;
            end else begin
                r_x[gi+1] <= r_x[gi] + (r_y[gi] >>> gi);
                r_y[gi+1] <= r_y[gi] - (r_x[gi] >>> gi);
                r_z[gi+1] <= r_z[gi] + atn;
            end
            r_flip[gi+1] <= r_flip[gi];
        end
    end

    // undo the half-turn fold
    always_ff @(posedge i_clk) begin
        if (r_flip[STEPS]) begin
            o_cos <= -r_x[STEPS];
            o_sin <= -r_y[STEPS];
        end else begin
            o_cos <= r_x[STEPS];
            o_sin <= r_y[STEPS];
        end
    end

endmodule

### sv/sen_cordic_vec.sv
// Pipelined CORDIC vectoring: atan2 in Q0.32 turns and gain-corrected magnitude.
module sen_cordic_vec import sen_pkg::*; #(
    parameter int STEPS = 32
) (
    input  logic        i_clk,
    input  t_cw         i_x,
    input  t_cw         i_y,
    output logic [31:0] o_angle,
    output t_cw         o_mag
);

    t_cw         r_x [STEPS+1];
    t_cw         r_y [STEPS+1];
    logic [31:0] r_z [STEPS+1];
    t_cw                   x_clip;
    logic signed [2*CW-1:0] mag_prod;

    // left half plane: mirror through the origin and start at half a turn
    always_ff @(posedge i_clk) begin
        if (i_x < 0) begin
            r_x[0] <= -i_x;
            r_y[0] <= -i_y;
            r_z[0] <= 32'h8000_0000;
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= 32'h0000_0000;
        end
    end

    for (genvar gi = 0; gi < STEPS; gi++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (r_y[gi] > 0) begin
                r_x[gi+1] <= r_x[gi] + (r_y[gi] >>> gi);
                r_y[gi+1] <= r_y[gi] - (r_x[gi] >>> gi);
                r_z[gi+1] <= r_z[gi] + atan_turn(6'(gi));
            end else begin
                r_x[gi+1] <= r_x[gi] - (r_y[gi] >>> gi);
                r_y[gi+1] <= r_y[gi] + (r_x[gi] >>> gi);
                r_z[gi+1] <= r_z[gi] - atan_turn(6'(gi));
            end
        end
    end

    // gain correction of the final x
    always_comb begin
        x_clip   = (r_x[STEPS] < 0) ? t_cw'(0) : r_x[STEPS];
        mag_prod = x_clip * GAIN_Q30;
    end

    always_ff @(posedge i_clk) begin
        o_angle <= r_z[STEPS];
        o_mag   <= t_cw'(mag_prod >>> 30);
    end

endmodule

### sv/sen_isqrt.sv
// Pipelined integer square root of a 61-bit value, one result bit per stage.
module sen_isqrt (
    input  logic        i_clk,
    input  logic [60:0] i_v,
    output logic [30:0] o_root
);

    logic [60:0] v_in [31];
    logic [61:0] q_in [31];
    logic [60:0] r_v  [31];
    logic [61:0] r_q  [31];

    for (genvar gi = 0; gi < 31; gi++) begin : g_bit
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * gi);
        logic [61:0] trial;

        if (gi == 0) begin : g_first
            assign v_in[gi] = i_v;
            assign q_in[gi] = '0;
        end else begin : g_next
            assign v_in[gi] = r_v[gi-1];
            assign q_in[gi] = r_q[gi-1];
        end

        assign trial = q_in[gi] + BIT;

        // restoring step: take the bit when the remainder covers the trial
        always_ff @(posedge i_clk) begin
            if ({1'b0, v_in[gi]} >= trial) begin
                r_v[gi] <= v_in[gi] - trial[60:0];
                r_q[gi] <= (q_in[gi] >> 1) + BIT;
            end else begin
                r_v[gi] <= v_in[gi];
                r_q[gi] <= q_in[gi] >> 1;
            end
        end
    end

    assign o_root = r_q[30][30:0];

endmodule

### sv/solar_elevation_night_dimmer.sv
// A result strobes on o_valid once it has passed through five chained CORDIC
// pipelines and the 31-stage square root.
// Throughput: one timestamp per cycle; busy is raised only in reset, the receiver cannot stall.
// Reset (synchronous, active low) clears the valid pipeline and loads the register defaults.
module solar_elevation_night_dimmer import sen_pkg::*; #(
    parameter int CORDIC_STEPS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_utc_seconds,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [24:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [14:0] o_elevation_centideg,
    output logic               o_is_night,
    output logic [7:0]         o_target_brightness,
    output logic               o_time_valid
);

    // time base and orbital constants (rates in turns/s * 2^56, offsets in turns * 2^32)
    localparam logic [32:0] EPOCH_OFS  = 33'd946728000;
    localparam logic [31:0] TIME_MIN   = 32'd1600000000;
    localparam logic [39:0] RATE_MLON  = 40'd2283416287;
    localparam logic [39:0] RATE_ANOM  = 40'd2283307172;
    localparam logic [39:0] RATE_EPS   = 40'd926;
    localparam logic [39:0] RATE_GMST  = 40'd836283347204;
    localparam logic [31:0] OFS_MLON   = 32'd3346018132;
    localparam logic [31:0] OFS_ANOM   = 32'd4265475187;
    localparam logic [31:0] OFS_EPS    = 32'd279638162;
    localparam logic [31:0] OFS_GMST   = 32'd3346025510;
    localparam t_cw         K_EQC1     = 34'sd22846839;
    localparam t_cw         K_EQC2     = 34'sd238609;
    localparam logic signed [31:0] DUSK_TURN = 32'sd9938077;
    localparam logic [26:0] RECIP_45   = 27'd95443718;
    localparam logic signed [67:0] TWO_P60 = 68'sh1000_0000_0000_0000;

    // stage numbers along the pipeline
    localparam int LR     = CORDIC_STEPS + 2;
    localparam int LV     = CORDIC_STEPS + 2;
    localparam int LS     = 31;
    localparam int ST_P1  = LR + 3;
    localparam int ST_LAM = ST_P1 + 1;
    localparam int ST_Q1  = ST_LAM + LR + 1;
    localparam int ST_Q2  = ST_Q1 + 1;
    localparam int ST_H   = ST_Q2 + LV + 1;
    localparam int ST_M1  = ST_H + LR + 1;
    localparam int ST_M4  = ST_M1 + 3;
    localparam int ST_F1  = ST_M4 + LS + LV + 1;
    localparam int ST_F2  = ST_F1 + 1;

    // configuration registers
    logic signed [23:0] r_lat;
    logic signed [24:0] r_lon;
    logic               r_locv;
    logic               r_auto;
    logic [7:0]         r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat   <= '0;
            r_lon   <= '0;
            r_locv  <= 1'b0;
            r_auto  <= 1'b1;
            r_level <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LAT:   r_lat   <= $signed(i_cfg_data[23:0]);
                CFG_LON:   r_lon   <= $signed(i_cfg_data);
                CFG_LOCV:  r_locv  <= i_cfg_data[0];
                CFG_AUTO:  r_auto  <= i_cfg_data[0];
                CFG_LEVEL: r_level <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // no request is taken while reset is held
    assign busy = !i_rst_n;

    // valid bits travel beside the data
    logic [ST_F2:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ST_F2-1:0], start};
        end
    end

    // stage 0: capture the request
    logic [31:0] r0_utc;

    always_ff @(posedge i_clk) begin
        r0_utc <= i_utc_seconds;
    end

    // stage 1: time products and coordinate scaling
    logic [32:0] t_rel;
    logic [31:0] t_lo;
    logic [24:0] lon_abs;
    logic [23:0] lat_abs;
    logic [55:0] r1_pm, r1_pa, r1_pe, r1_pgl, r1_pgh;
    logic        r1_neg, r1_tv;
    logic [32:0] r1_lon_a, r1_lat_a;
    logic [20:0] r1_lon_b, r1_lat_b;
    logic        r1_lon_neg, r1_lat_neg;

    always_comb begin
        t_rel   = {1'b0, r0_utc} - EPOCH_OFS;
        t_lo    = t_rel[31:0];
        lon_abs = r_lon[24] ? 25'(-r_lon) : r_lon;
        lat_abs = r_lat[23] ? 24'(-r_lat) : r_lat;
    end

    always_ff @(posedge i_clk) begin
        r1_pm      <= 56'(64'(t_lo) * 64'(RATE_MLON));
        r1_pa      <= 56'(64'(t_lo) * 64'(RATE_ANOM));
        r1_pe      <= 56'(64'(t_lo) * 64'(RATE_EPS));
        r1_pgl     <= 56'(64'(t_lo) * 64'(RATE_GMST[31:0]));
        r1_pgh     <= 56'(64'(t_lo) * 64'(RATE_GMST[39:32]));
        r1_neg     <= t_rel[32];
        r1_tv      <= r0_utc > TIME_MIN;
        // q16 * 8192 / 45 = q16 * 182 + floor(2 * q16 / 45)
        r1_lon_a   <= 33'(33'(lon_abs) * 33'd182);
        r1_lon_b   <= 21'((53'({lon_abs, 1'b0}) * 53'(RECIP_45)) >> 32);
        r1_lon_neg <= r_lon[24];
        r1_lat_a   <= 33'(33'(lat_abs) * 33'd182);
        r1_lat_b   <= 21'((53'({lat_abs, 1'b0}) * 53'(RECIP_45)) >> 32);
        r1_lat_neg <= r_lat[23];
    end

    // stage 2: angles from the products, modulo one turn
    function automatic logic [31:0] drift(input logic [55:0] prod, input logic [39:0] rate,
                                          input logic neg);
        logic [55:0] w;
        w = prod - (neg ? 56'({rate, 32'd0}) : 56'd0);
        return w[55:24];
    endfunction

    logic [32:0] lon_q, lat_q;
    logic [31:0] r2_mlon, r2_anom, r2_eps, r2_gmst, r2_lon_turn, r2_lat_turn;
    logic        r2_tv;

    always_comb begin
        lon_q = r1_lon_a + 33'(r1_lon_b);
        lat_q = r1_lat_a + 33'(r1_lat_b);
    end

    always_ff @(posedge i_clk) begin
        r2_mlon     <= OFS_MLON + drift(r1_pm, RATE_MLON, r1_neg);
        r2_anom     <= OFS_ANOM + drift(r1_pa, RATE_ANOM, r1_neg);
        r2_eps      <= OFS_EPS - drift(r1_pe, RATE_EPS, r1_neg);
        r2_gmst     <= OFS_GMST + drift(r1_pgl + (r1_pgh << 32), RATE_GMST, r1_neg);
        r2_lon_turn <= r1_lon_neg ? 32'(-lon_q) : lon_q[31:0];
        r2_lat_turn <= r1_lat_neg ? 32'(-lat_q) : lat_q[31:0];
        r2_tv       <= r1_tv;
    end

    // anomaly terms and latitude rotation
    t_cw sin_g, sin_2g, clat, slat;
    t_cw unused_cg, unused_c2g;

    sen_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_g (
        .i_clk(i_clk), .i_angle(r2_anom), .o_cos(unused_cg), .o_sin(sin_g)
    );
    sen_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_g2 (
        .i_clk(i_clk), .i_angle({r2_anom[30:0], 1'b0}), .o_cos(unused_c2g), .o_sin(sin_2g)
    );
    sen_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_lat (
        .i_clk(i_clk), .i_angle(r2_lat_turn), .o_cos(clat), .o_sin(slat)
    );

    logic [31:0] mlon_d, eps_d, gl_d;
    logic        tv_d;

    sen_delay #(.WIDTH(32), .DEPTH(ST_P1 - 2)) u_dly_mlon (
        .i_clk(i_clk), .i_d(r2_mlon), .o_d(mlon_d)
    );
    sen_delay #(.WIDTH(32), .DEPTH(ST_LAM - 2)) u_dly_eps (
        .i_clk(i_clk), .i_d(r2_eps), .o_d(eps_d)
    );
    sen_delay #(.WIDTH(32), .DEPTH(ST_H - 3)) u_dly_gl (
        .i_clk(i_clk), .i_d(r2_gmst + r2_lon_turn), .o_d(gl_d)
    );
    sen_delay #(.WIDTH(1), .DEPTH(ST_F1 - 3)) u_dly_tv (
        .i_clk(i_clk), .i_d(r2_tv), .o_d(tv_d)
    );

    // equation of center and ecliptic longitude
    logic signed [2*CW-1:0] r_p1_a, r_p1_b;
    logic [31:0]            r_lam;

    always_ff @(posedge i_clk) begin
        r_p1_a <= sin_g * K_EQC1;
        r_p1_b <= sin_2g * K_EQC2;
        r_lam  <= mlon_d + 32'(r_p1_a >>> 30) + 32'(r_p1_b >>> 30);
    end

    t_cw cos_l, sin_l, cos_e, sin_e;

    sen_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_lam (
        .i_clk(i_clk), .i_angle(r_lam), .o_cos(cos_l), .o_sin(sin_l)
    );
    sen_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_eps (
        .i_clk(i_clk), .i_angle(eps_d), .o_cos(cos_e), .o_sin(sin_e)
    );

    // declination sine and the right ascension vector
    logic signed [2*CW-1:0] r_q1_sdec, r_q1_y;
    t_cw                    r_q1_x, r_q2_x, r_q2_y, r_q2_sdec;

    always_ff @(posedge i_clk) begin
        r_q1_sdec <= sin_e * sin_l;
        r_q1_y    <= cos_e * sin_l;
        r_q1_x    <= cos_l;
        r_q2_sdec <= t_cw'(r_q1_sdec >>> 30);
        r_q2_y    <= t_cw'(r_q1_y >>> 30);
        r_q2_x    <= r_q1_x;
    end

    logic [31:0] ra;
    t_cw         cdec;

    sen_cordic_vec #(.STEPS(CORDIC_STEPS)) u_vec_ra (
        .i_clk(i_clk), .i_x(r_q2_x), .i_y(r_q2_y), .o_angle(ra), .o_mag(cdec)
    );

    // hour angle
    logic [31:0] r_hang;

    always_ff @(posedge i_clk) begin
        r_hang <= gl_d - ra;
    end

    t_cw cos_h, unused_sh;

    sen_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_h (
        .i_clk(i_clk), .i_angle(r_hang), .o_cos(cos_h), .o_sin(unused_sh)
    );

    logic [CW-1:0] clat_d, slat_d, sdec_d, cdec_d;

    sen_delay #(.WIDTH(CW), .DEPTH(ST_M1 - 3 - LR)) u_dly_clat (
        .i_clk(i_clk), .i_d(clat), .o_d(clat_d)
    );
    sen_delay #(.WIDTH(CW), .DEPTH(ST_M1 - 3 - LR)) u_dly_slat (
        .i_clk(i_clk), .i_d(slat), .o_d(slat_d)
    );
    sen_delay #(.WIDTH(CW), .DEPTH(ST_M1 - 1 - ST_Q2)) u_dly_sdec (
        .i_clk(i_clk), .i_d(r_q2_sdec), .o_d(sdec_d)
    );
    sen_delay #(.WIDTH(CW), .DEPTH(ST_M1 - ST_H)) u_dly_cdec (
        .i_clk(i_clk), .i_d(cdec), .o_d(cdec_d)
    );

    // sine of elevation, clamp, and the cosine argument for the square root
    logic signed [2*CW-1:0] r_m1_p1, r_m1_p2, r_m2_p3;
    t_cw                    r_m1_ch, r_m2_p1, r_m3_s, r_m4_s, s_sum;
    logic signed [2*CW-1:0] s_sq;
    logic [60:0]            r_m4_v;

    always_comb begin
        s_sum = r_m2_p1 + t_cw'(r_m2_p3 >>> 30);
        s_sq  = r_m3_s * r_m3_s;
    end

    always_ff @(posedge i_clk) begin
        r_m1_p1 <= $signed(slat_d) * $signed(sdec_d);
        r_m1_p2 <= $signed(clat_d) * $signed(cdec_d);
        r_m1_ch <= cos_h;
        r_m2_p1 <= t_cw'(r_m1_p1 >>> 30);
        r_m2_p3 <= t_cw'(r_m1_p2 >>> 30) * r_m1_ch;
        if (s_sum > ONE_Q30) begin
            r_m3_s <= ONE_Q30;
        end else if (s_sum < -ONE_Q30) begin
            r_m3_s <= -ONE_Q30;
        end else begin
            r_m3_s <= s_sum;
        end
        r_m4_v <= 61'(TWO_P60 - s_sq);
        r_m4_s <= r_m3_s;
    end

    logic [30:0]   cos_el;
    logic [CW-1:0] s_d;

    sen_isqrt u_sqrt (
        .i_clk(i_clk), .i_v(r_m4_v), .o_root(cos_el)
    );
    sen_delay #(.WIDTH(CW), .DEPTH(LS)) u_dly_s (
        .i_clk(i_clk), .i_d(r_m4_s), .o_d(s_d)
    );

    logic [31:0] elev;
    t_cw         unused_mag;

    sen_cordic_vec #(.STEPS(CORDIC_STEPS)) u_vec_el (
        .i_clk(i_clk), .i_x($signed({{(CW-31){1'b0}}, cos_el})), .i_y($signed(s_d)),
        .o_angle(elev), .o_mag(unused_mag)
    );

    // centidegree rounding and dusk test
    logic signed [63:0] cdeg_raw;
    logic signed [16:0] r_f1_rnd;
    logic               r_f1_dark, r_f1_tv;

    always_comb begin
        cdeg_raw = $signed({{32{elev[31]}}, elev}) * 64'sd36000 + 64'sd2147483648;
    end

    always_ff @(posedge i_clk) begin
        r_f1_rnd  <= 17'(cdeg_raw >>> 32);
        r_f1_dark <= $signed(elev) < -DUSK_TURN;
        r_f1_tv   <= tv_d;
    end

    // result register
    logic               night;
    logic [17:0]        lvl_div;
    logic [7:0]         dim_lvl;
    logic signed [14:0] r_elev;
    logic               r_night, r_tvo;
    logic [7:0]         r_bright;

    always_comb begin
        night   = r_auto & r_locv & r_f1_tv & r_f1_dark;
        // level / 5 for 8-bit levels
        lvl_div = 18'(r_level) * 18'd205;
        dim_lvl = (lvl_div[17:10] < 8'd10) ? 8'd10 : lvl_div[17:10];
    end

    always_ff @(posedge i_clk) begin
        if (r_f1_rnd > 17'sd9000) begin
            r_elev <= 15'sd9000;
        end else if (r_f1_rnd < -17'sd9000) begin
            r_elev <= -15'sd9000;
        end else begin
            r_elev <= 15'(r_f1_rnd);
        end
        r_night  <= night;
        r_bright <= night ? dim_lvl : r_level;
        r_tvo    <= r_f1_tv;
    end

    assign o_valid              = r_vld[ST_F2];
    assign o_elevation_centideg = r_elev;
    assign o_is_night           = r_night;
    assign o_target_brightness  = r_bright;
    assign o_time_valid         = r_tvo;

endmodule
